FILE: rtl/alpfp_pkg.sv
// package for the length-prefixed ascii frame parser
// holds status codes, header and trailer characters and defaults; no dependencies
package alpfp_pkg;

  localparam int LEN_WIDTH_DEF = 16;

  localparam int MAXP_W = 16;
  localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RST = 16'd4096;

  // apb register map
  localparam int CFG_AW = 3;
  localparam logic CFG_IDX_MAX_PAYLOAD = 1'b0;

  // result status codes
  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_OK   = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  localparam int HDR_LEN = 6;
  localparam int TRL_LEN = 5;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // "PACKET"
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h50;
      3'd1: c = 8'h41;
      3'd2: c = 8'h43;
      3'd3: c = 8'h4b;
      3'd4: c = 8'h45;
      3'd5: c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // ",EPCK"
  function automatic logic [7:0] trl_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h2c;
      3'd1: c = 8'h45;
      3'd2: c = 8'h50;
      3'd3: c = 8'h43;
      3'd4: c = 8'h4b;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/ascii_length_prefixed_frame_parser.sv
// top level of the length-prefixed ascii frame parser (PACKET,<len>,<payload>,EPCK)
// depends on alpfp_pkg for status codes, frame characters and defaults
//
// Takes one received byte per transfer and gives at most one result per byte:
// a payload byte (status 0, last set on the final one), a frame accepted after
// a good ",EPCK" trailer (status 1) or a frame error (status 2) on a comma with
// no digits, a non-digit in the length, a length above max_payload or at the
// 2^LEN_WIDTH saturation value, or a bad trailer byte. A header not followed by
// a comma silently returns to hunting. The payload ends on the declared count,
// so "EPCK" inside the payload is plain data. Throughput is one byte per clock
// while out_ready is high: every byte passes an input register, the parsing
// logic (the length multiply-by-ten add is the deepest path) and a result
// register. While a result waits with out_ready low, the input register still
// takes one byte and then holds it until the result transfers. max_payload sits
// at apb address 0 (reset 4096).
module ascii_length_prefixed_frame_parser #(
  parameter int LEN_WIDTH = alpfp_pkg::LEN_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // byte input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_rx_byte,
  // result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  output logic [1:0]                  out_status,
  // apb configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [alpfp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import alpfp_pkg::*;

  localparam int AW = LEN_WIDTH + 1;   // length accumulator, holds the saturation value
  localparam int VW = LEN_WIDTH + 5;   // accum*10 + digit never overflows this
  localparam int CW = 33;              // compare width covering both accum and max_payload
  localparam logic [VW-1:0] LEN_CAP = VW'(1) << LEN_WIDTH;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_COMMA   = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TRAILER = 3'd4
  } phase_t;

  // configuration register
  logic [MAXP_W-1:0] max_payload_r;
  logic              cfg_wr;
  logic              cfg_idx;

  // input register
  logic              in_vld_r;
  logic [7:0]        byte_r;

  // parser state
  phase_t            phase_r, phase_nxt;
  logic [2:0]        match_r, match_nxt;
  logic [AW-1:0]     accum_r, accum_nxt;
  logic              digit_seen_r, digit_seen_nxt;
  logic [LEN_WIDTH-1:0] left_r, left_nxt;

  // result register
  logic              out_vld_r;
  logic [7:0]        out_byte_r, res_byte;
  logic              out_last_r, res_last;
  status_t           out_status_r, res_status;
  logic              res_vld;

  logic              advance;
  logic              is_digit;
  logic [3:0]        digit;
  logic [VW-1:0]     accum_x10;
  logic [VW-1:0]     accum_sum;
  logic [2:0]        rehunt_match;

  // apb side, no wait states
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_idx == CFG_IDX_MAX_PAYLOAD) ? 32'(max_payload_r) : 32'd0;

  // the parse stage moves when the result register is free or draining
  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || advance;

  assign out_valid  = out_vld_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  // length digit arithmetic: accum*10 as two shifts, saturate at 2^LEN_WIDTH
  always_comb begin
    is_digit     = (byte_r >= CH_ZERO) && (byte_r <= CH_NINE);
    digit        = 4'(byte_r - CH_ZERO);
    accum_x10    = (VW'(accum_r) << 3) + (VW'(accum_r) << 1);
    accum_sum    = accum_x10 + VW'(digit);
    rehunt_match = (byte_r == CH_P) ? 3'd1 : 3'd0;
  end

  // one byte through the frame state machine
  always_comb begin
    phase_nxt      = phase_r;
    match_nxt      = match_r;
    accum_nxt      = accum_r;
    digit_seen_nxt = digit_seen_r;
    left_nxt       = left_r;
    res_vld        = 1'b0;
    res_byte       = 8'd0;
    res_last       = 1'b0;
    res_status     = ST_DATA;

    case (phase_r)
      PH_COMMA: begin
        if (byte_r == CH_COMMA) begin
          phase_nxt      = PH_LEN;
          accum_nxt      = '0;
          digit_seen_nxt = 1'b0;
        end else begin
          // missing comma: back to hunting, this byte may start a header
          phase_nxt      = PH_HUNT;
          match_nxt      = rehunt_match;
          accum_nxt      = '0;
          digit_seen_nxt = 1'b0;
          left_nxt       = '0;
        end
      end

      PH_LEN: begin
        if (is_digit) begin
          accum_nxt      = (accum_sum > LEN_CAP) ? AW'(LEN_CAP) : AW'(accum_sum);
          digit_seen_nxt = 1'b1;
        end else if (byte_r == CH_COMMA && digit_seen_r && !accum_r[LEN_WIDTH]
                     && (CW'(accum_r) <= CW'(max_payload_r))) begin
          left_nxt  = accum_r[LEN_WIDTH-1:0];
          match_nxt = 3'd0;
          phase_nxt = (accum_r == '0) ? PH_TRAILER : PH_PAYLOAD;
        end else begin
          // empty, bad or overlong length
          phase_nxt      = PH_HUNT;
          match_nxt      = rehunt_match;
          accum_nxt      = '0;
          digit_seen_nxt = 1'b0;
          left_nxt       = '0;
          res_vld        = 1'b1;
          res_status     = ST_ERR;
        end
      end

      PH_PAYLOAD: begin
        res_vld    = 1'b1;
        res_byte   = byte_r;
        res_status = ST_DATA;
        if (left_r[LEN_WIDTH-1:1] == '0) begin
          res_last  = 1'b1;
          left_nxt  = '0;
          phase_nxt = PH_TRAILER;
          match_nxt = 3'd0;
        end else begin
          left_nxt = left_r - LEN_WIDTH'(1);
        end
      end

      PH_TRAILER: begin
        if (match_r < 3'(TRL_LEN) && byte_r == trl_char(match_r)) begin
          if (match_r == 3'(TRL_LEN - 1)) begin
            // full trailer seen, frame done
            phase_nxt      = PH_HUNT;
            match_nxt      = 3'd0;
            accum_nxt      = '0;
            digit_seen_nxt = 1'b0;
            left_nxt       = '0;
            res_vld        = 1'b1;
            res_status     = ST_OK;
          end else begin
            match_nxt = match_r + 3'd1;
          end
        end else begin
          phase_nxt      = PH_HUNT;
          match_nxt      = rehunt_match;
          accum_nxt      = '0;
          digit_seen_nxt = 1'b0;
          left_nxt       = '0;
          res_vld        = 1'b1;
          res_status     = ST_ERR;
        end
      end

      default: begin
        // hunting: only a 'P' can restart a partial header match
        if (match_r < 3'(HDR_LEN) && byte_r == hdr_char(match_r)) begin
          if (match_r == 3'(HDR_LEN - 1)) begin
            phase_nxt = PH_COMMA;
            match_nxt = 3'd0;
          end else begin
            match_nxt = match_r + 3'd1;
          end
        end else begin
          phase_nxt      = PH_HUNT;
          match_nxt      = rehunt_match;
          accum_nxt      = '0;
          digit_seen_nxt = 1'b0;
          left_nxt       = '0;
        end
      end
    endcase
  end

  // state, input register, result register and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
      in_vld_r      <= 1'b0;
      phase_r       <= PH_HUNT;
      match_r       <= 3'd0;
      accum_r       <= '0;
      digit_seen_r  <= 1'b0;
      left_r        <= '0;
      out_vld_r     <= 1'b0;
      out_status_r  <= ST_DATA;
      out_last_r    <= 1'b0;
    end else begin
      if (cfg_wr && cfg_idx == CFG_IDX_MAX_PAYLOAD) begin
        max_payload_r <= cfg_pwdata[MAXP_W-1:0];
      end

      if (in_ready) begin
        in_vld_r <= in_valid;
      end

      if (advance) begin
        out_vld_r <= in_vld_r && res_vld;
      end

      if (in_vld_r && advance) begin
        phase_r      <= phase_nxt;
        match_r      <= match_nxt;
        accum_r      <= accum_nxt;
        digit_seen_r <= digit_seen_nxt;
        left_r       <= left_nxt;
        if (res_vld) begin
          out_status_r <= res_status;
          out_last_r   <= res_last;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_rx_byte;
    end
    if (in_vld_r && advance && res_vld) begin
      out_byte_r <= res_byte;
    end
  end

  // a pending result is never overwritten before its transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |=> out_vld_r && $stable(out_byte_r) && $stable(out_status_r))
    else $error("pending result lost or changed");

  // only payload results carry a byte or the last mark
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_status_r != ST_DATA |-> out_byte_r == 8'd0 && !out_last_r)
    else $error("non-data result carries payload");

  // inside a payload there is always at least one byte left
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> left_r != '0)
    else $error("payload phase with empty count");

  // match index stays within the header or trailer being matched
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HUNT || match_r < 3'(HDR_LEN)) &&
    (phase_r != PH_TRAILER || match_r < 3'(TRL_LEN)))
    else $error("match index out of range");

  // the length never passes the saturation value
  assert property (@(posedge clk) disable iff (!rst_n)
    VW'(accum_r) <= LEN_CAP)
    else $error("length accumulator above saturation");

endmodule
